// ===== src/spts_pkg.sv =====
// Shared types for the sorted pair target sum block.
package spts_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 33;
  localparam int unsigned POS_W = 8;

  typedef struct packed {
    logic ins;
    logic shl;
    logic clr;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

endpackage

// ===== src/sorted_pair_target_sum.sv =====
// Top level: insertion-sort cell chains and two-pointer pair search.
//
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall   | in_value, in_last_item
// out_    | output    | out_valid / out_stall | out_found, out_low_position,
//         |           |                       | out_high_position, out_overflow
// cfg_    | input     | cfg_we                | cfg_target_sum
//
// Each item is inserted into both cell chains in one step.
// After the last item the search moves one pointer per step, at most
// (stored count - 1) moves in all, using the single 33-bit add and compare.
// rst_n is synchronous; it empties the chains and returns to loading.
// Items are held off (in_stall) only during the search; a result waiting on
// out_stall holds the search at its final step.
module sorted_pair_target_sum #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [spts_pkg::VAL_W-1:0] in_value,
  input  logic                              in_last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [spts_pkg::POS_W-1:0]        out_low_position,
  output logic [spts_pkg::POS_W-1:0]        out_high_position,
  output logic                              out_overflow,
  input  logic                              cfg_we,
  input  logic signed [spts_pkg::VAL_W-1:0] cfg_target_sum
);

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SUM_W = spts_pkg::SUM_W;

  spts_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] lp_r, lp_nxt, rp_r, rp_nxt;
  logic signed [spts_pkg::VAL_W-1:0] target_r;

  logic                       out_valid_r, out_valid_nxt;
  logic                       found_r, found_nxt;
  logic [spts_pkg::POS_W-1:0] lpos_r, lpos_nxt, hpos_r, hpos_nxt;
  logic                       oovf_r, oovf_nxt;

  spts_pkg::cell_cmd_t cmd_a, cmd_b;

  logic signed [spts_pkg::VAL_W-1:0] a_val [MAX_ELEMENTS];
  logic signed [spts_pkg::VAL_W-1:0] b_val [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] a_valid, b_valid, a_gt, b_gt;

  logic accept, drop, ins;
  logic [CNT_W-1:0] cnt_after;
  logic signed [spts_pkg::SUM_W-1:0] sum, tgt;
  logic done_nf, hit, can_out;

  assign in_stall = (state_r == spts_pkg::ST_SEARCH);
  assign accept   = in_valid && !in_stall;
  assign drop     = (cnt_r == CNT_W'(MAX_ELEMENTS));
  assign ins      = accept && !drop;
  assign cnt_after = ins ? cnt_r + CNT_W'(1) : cnt_r;

  // Front of the ascending chain is sorted[lp], front of the descending one sorted[rp]
  assign sum     = SUM_W'(a_val[0]) + SUM_W'(b_val[0]);
  assign tgt     = SUM_W'(target_r);
  assign done_nf = (lp_r >= rp_r);
  assign hit     = !done_nf && (sum == tgt);
  assign can_out = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    lp_nxt        = lp_r;
    rp_nxt        = rp_r;
    out_valid_nxt = out_valid_r && out_stall;
    found_nxt     = found_r;
    lpos_nxt      = lpos_r;
    hpos_nxt      = hpos_r;
    oovf_nxt      = oovf_r;
    cmd_a         = '0;
    cmd_b         = '0;
    case (state_r)
      spts_pkg::ST_LOAD: begin
        if (accept) begin
          cmd_a.ins = ins;
          cmd_b.ins = ins;
          cnt_nxt   = cnt_after;
          ovf_nxt   = ovf_r || drop;
          if (in_last_item) begin
            state_nxt = spts_pkg::ST_SEARCH;
            lp_nxt    = '0;
            rp_nxt    = (cnt_after == '0) ? '0 : IDX_W'(cnt_after - CNT_W'(1));
          end
        end
      end
      spts_pkg::ST_SEARCH: begin
        if (done_nf || hit) begin
          // Publish once the output slot is free, then empty the chains
          if (can_out) begin
            out_valid_nxt = 1'b1;
            found_nxt     = hit;
            lpos_nxt      = hit ? spts_pkg::POS_W'(lp_r) : '0;
            hpos_nxt      = hit ? spts_pkg::POS_W'(rp_r) : '0;
            oovf_nxt      = ovf_r;
            cmd_a.clr     = 1'b1;
            cmd_b.clr     = 1'b1;
            cnt_nxt       = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = spts_pkg::ST_LOAD;
          end
        end else if (sum > tgt) begin
          rp_nxt    = rp_r - IDX_W'(1);
          cmd_b.shl = 1'b1;
        end else begin
          lp_nxt    = lp_r + IDX_W'(1);
          cmd_a.shl = 1'b1;
        end
      end
      default: begin
        state_nxt = spts_pkg::ST_LOAD;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
      logic                              a_lgt, b_lgt, a_lv, b_lv, a_rv, b_rv;
      logic signed [spts_pkg::VAL_W-1:0] a_l, b_l, a_r, b_r;
      if (gi == 0) begin : g_head
        assign a_lgt = 1'b0;
        assign b_lgt = 1'b0;
        assign a_l   = in_value;
        assign b_l   = in_value;
        assign a_lv  = 1'b1;
        assign b_lv  = 1'b1;
      end else begin : g_body
        assign a_lgt = a_gt[gi-1];
        assign b_lgt = b_gt[gi-1];
        assign a_l   = a_val[gi-1];
        assign b_l   = b_val[gi-1];
        assign a_lv  = a_valid[gi-1];
        assign b_lv  = b_valid[gi-1];
      end
      if (gi == MAX_ELEMENTS - 1) begin : g_tail
        assign a_r  = a_val[gi];
        assign b_r  = b_val[gi];
        assign a_rv = 1'b0;
        assign b_rv = 1'b0;
      end else begin : g_mid
        assign a_r  = a_val[gi+1];
        assign b_r  = b_val[gi+1];
        assign a_rv = a_valid[gi+1];
        assign b_rv = b_valid[gi+1];
      end
      spts_cell #(.DESC(1'b0)) u_a (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_a), .ins_val(in_value),
        .left_gt(a_lgt), .left_val(a_l), .left_valid(a_lv),
        .right_val(a_r), .right_valid(a_rv),
        .gt(a_gt[gi]), .val(a_val[gi]), .valid(a_valid[gi])
      );
      spts_cell #(.DESC(1'b1)) u_b (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_b), .ins_val(in_value),
        .left_gt(b_lgt), .left_val(b_l), .left_valid(b_lv),
        .right_val(b_r), .right_valid(b_rv),
        .gt(b_gt[gi]), .val(b_val[gi]), .valid(b_valid[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    lp_r   <= lp_nxt;
    rp_r   <= rp_nxt;
    found_r <= found_nxt;
    lpos_r <= lpos_nxt;
    hpos_r <= hpos_nxt;
    oovf_r <= oovf_nxt;
    if (!rst_n) begin
      state_r     <= spts_pkg::ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        target_r <= cfg_target_sum;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_low_position  = lpos_r;
  assign out_high_position = hpos_r;
  assign out_overflow      = oovf_r;

endmodule

// ===== src/spts_cell.sv =====
// One sorting cell: holds one value and trades it with its neighbors.
module spts_cell #(
  parameter bit DESC = 1'b0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spts_pkg::cell_cmd_t               cmd,
  input  logic signed [spts_pkg::VAL_W-1:0] ins_val,
  input  logic                              left_gt,
  input  logic signed [spts_pkg::VAL_W-1:0] left_val,
  input  logic                              left_valid,
  input  logic signed [spts_pkg::VAL_W-1:0] right_val,
  input  logic                              right_valid,
  output logic                              gt,
  output logic signed [spts_pkg::VAL_W-1:0] val,
  output logic                              valid
);

  logic signed [spts_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                              valid_r, valid_nxt;

  // Empty cells rank after every value
  assign gt    = !valid_r || (DESC ? (val_r < ins_val) : (val_r > ins_val));
  assign val   = val_r;
  assign valid = valid_r;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.shl) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (cmd.ins && gt) begin
      if (left_gt) begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end else begin
        val_nxt   = ins_val;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== src/spts_checker.sv =====
// Port-level checker for the sorted pair target sum block, with its bind.
module spts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_found,
  input logic [spts_pkg::POS_W-1:0] out_low_position,
  input logic [spts_pkg::POS_W-1:0] out_high_position
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_low_position) && $stable(out_high_position))
    else $error("stalled result changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_low_position == '0 && out_high_position == '0)
    else $error("positions set without a pair");

  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found && out_high_position != '0 |->
      out_low_position != out_high_position)
    else $error("pair members share a position");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("activity right after reset");

endmodule

bind sorted_pair_target_sum spts_checker u_spts_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_found(out_found),
  .out_low_position(out_low_position), .out_high_position(out_high_position)
);

// ===== dv/testbench.sv =====
// Testbench for sorted_pair_target_sum: directed and random sets checked against a sort and pair search.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned VAL_W = spts_pkg::VAL_W;
  localparam int unsigned SUM_W = spts_pkg::SUM_W;
  localparam int unsigned POS_W = spts_pkg::POS_W;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [POS_W-1:0] out_low_position;
  logic [POS_W-1:0] out_high_position;
  logic out_overflow;
  logic cfg_we = 1'b0;
  logic signed [VAL_W-1:0] cfg_target_sum = '0;

  typedef struct packed {
    logic found;
    logic [POS_W-1:0] low_pos;
    logic [POS_W-1:0] high_pos;
    logic overflow;
  } pair_result_t;

  // Predictor state: the sorted set, its fill and the programmed target.
  logic signed [VAL_W-1:0] sorted_set[CAPACITY];
  int unsigned set_count;
  bit set_dropped;
  logic signed [VAL_W-1:0] target;
  pair_result_t pending_pairs[$];

  int unsigned error_count;
  int unsigned idle_cycles = 0;
  bit timed_out;
  int unsigned burst_left;

  sorted_pair_target_sum #(.MAX_ELEMENTS(CAPACITY)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_value(in_value), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_low_position(out_low_position),
    .out_high_position(out_high_position), .out_overflow(out_overflow),
    .cfg_we(cfg_we), .cfg_target_sum(cfg_target_sum)
  );

  always #2 clk = ~clk;

  // Insert one value and, on the last one, run the two-pointer walk.
  function automatic void predict_pair(logic signed [VAL_W-1:0] v, logic last);
    int unsigned i;
    int unsigned lo;
    int unsigned hi;
    logic signed [SUM_W-1:0] s;
    pair_result_t r;
    if (set_count >= CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      i = set_count;
      while (i > 0 && sorted_set[i-1] > v) begin
        sorted_set[i] = sorted_set[i-1];
        i--;
      end
      sorted_set[i] = v;
      set_count++;
    end
    if (!last) return;
    r = '0;
    lo = 0;
    hi = (set_count > 0) ? set_count - 1 : 0;
    while (lo < hi) begin
      s = SUM_W'(sorted_set[lo]) + SUM_W'(sorted_set[hi]);
      if (s == SUM_W'(target)) begin
        r.found = 1'b1;
        break;
      end else if (s > SUM_W'(target)) begin
        hi--;
      end else begin
        lo++;
      end
    end
    if (r.found) begin
      r.low_pos = POS_W'(lo);
      r.high_pos = POS_W'(hi);
    end
    r.overflow = set_dropped;
    pending_pairs.push_back(r);
    set_count = 0;
    set_dropped = 1'b0;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Receiver: stall on a pattern that changes mode now and then, check each item.
  int unsigned stall_mode;
  always @(posedge clk) begin
    pair_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_pairs.pop_front();
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_low_position !== want.low_pos)
          report_mismatch("low_position", out_low_position, want.low_pos);
        if (out_high_position !== want.high_pos)
          report_mismatch("high_position", out_high_position, want.high_pos);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Send one item: hold it until accepted, gaps between random bursts.
  task automatic send_item(logic signed [VAL_W-1:0] v, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= v;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pair(v, last);
  endtask

  // Drop valid, drain all results, let the search settle, then write target.
  task automatic set_target(logic signed [VAL_W-1:0] t);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_target_sum <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    target = t;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value(int unsigned span);
    if (span == 0) return $signed($urandom());
    return $signed(VAL_W'($urandom_range(0, 2 * span))) - $signed(VAL_W'(span));
  endfunction

  task automatic send_set(logic signed [VAL_W-1:0] vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // Directed: extremes, single element, no pair, wide sums.
  task automatic test_directed();
    set_target(32'sh0);
    send_set('{32'sh7fffffff, 32'sh80000000, 32'sh1});
    send_set('{32'sh5});
    send_set('{32'sh1, 32'sh2, 32'sh4});
    send_set('{-32'sh3, 32'sh3, 32'sh0, 32'sh0});
    set_target(32'sh7fffffff);
    send_set('{32'sh7fffffff, 32'sh7fffffff, 32'sh0});
    set_target(32'sh80000000);
    send_set('{32'sh80000000, 32'sh80000000, 32'sh0, -32'sh1});
    send_set('{32'sh40000000, -32'sh40000000});
  endtask

  // Overflow: exceed capacity, including a dropped last item.
  task automatic test_capacity();
    logic signed [VAL_W-1:0] vals[$];
    set_target(32'sh10);
    for (int k = 0; k < CAPACITY + 3; k++) vals.push_back(rand_value(40));
    send_set(vals);
    vals.delete();
    for (int k = 0; k < CAPACITY; k++) vals.push_back(rand_value(40));
    send_set(vals);
  endtask

  // Random sets, mostly small, values chosen so pairs are often present.
  task automatic test_random_sets(int unsigned items, logic signed [VAL_W-1:0] t);
    int unsigned sent;
    int unsigned len;
    int unsigned span;
    logic signed [VAL_W-1:0] vals[$];
    logic signed [VAL_W-1:0] a;
    set_target(t);
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      span = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      vals.delete();
      for (int k = 0; k < len; k++) vals.push_back(rand_value(span));
      if (len >= 2 && $urandom_range(0, 1)) begin
        a = vals[$urandom_range(0, len - 1)];
        vals[$urandom_range(0, len - 1)] = t - a;
      end
      send_set(vals);
      sent += len;
    end
  endtask

  initial begin
    error_count = 0;
    set_count = 0;
    set_dropped = 1'b0;
    target = '0;
    burst_left = 0;
    stall_mode = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random_sets(140, 32'sh0);
    test_random_sets(130, $signed($urandom()));
    test_random_sets(145, $signed(VAL_W'($urandom_range(0, 40))) - 20);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
